// ===== hdl/dotq_pkg.sv =====
// Package with the state encoding and result status codes of the deadline-ordered task queue.
package dotq_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_EXP_CMP,
		ST_EXP_FIN,
		ST_ACK
	} dotq_state_t;

	typedef logic [1:0] dotq_status_t;

	localparam dotq_status_t STATUS_ACCEPTED = 2'd0;
	localparam dotq_status_t STATUS_FULL     = 2'd1;
	localparam dotq_status_t STATUS_FIRED    = 2'd2;
	localparam dotq_status_t STATUS_NOTHING  = 2'd3;

	localparam logic FUNC_SCHEDULE = 1'b0;
	localparam logic FUNC_EXPIRE   = 1'b1;

endpackage

// ===== hdl/deadline_ordered_task_queue.sv =====
// Top level of the deadline-ordered task queue, a sorted circular buffer in one memory.
// The queue holds up to DEPTH tasks in one memory used as a circular buffer, sorted by due time,
// with ties kept in arrival order. A schedule item takes longer for every pending task with a later
// due time, since the insert walks back from the tail and moves one entry per cycle through the
// single read and write port; a full queue answers without any walk. An expire item takes longer
// for every fired task, as the head is read, compared and released one entry per cycle while the
// output is not stalled; an empty queue answers without any walk. A stalled output delays the
// expire walk and every result. The next item is accepted once the previous one has produced its
// last result, which may still sit in the output register. There is no clearing pass after reset.
module deadline_ordered_task_queue import dotq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] time_value,
	input  logic [15:0] task_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] fired_handle,
	output logic [1:0]  status,
	output logic        last,
	output logic [4:0]  task_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [47:0]   entry_t;

	entry_t mem [DEPTH];
	entry_t rd_q;

	dotq_state_t state_q, state_d;

	addr_t        head_q;
	cnt_t         cnt_q;
	cnt_t         j_q;
	logic [31:0]  tval_q;
	logic [15:0]  hnd_q;
	logic [15:0]  pend_q;
	logic         pend_valid_q;
	dotq_status_t ack_status_q;

	logic         out_valid_q;
	logic [15:0]  out_handle_q;
	dotq_status_t out_status_q;
	logic         out_last_q;
	cnt_t         out_count_q;

	logic         mem_we, mem_re;
	addr_t        mem_wa, mem_ra;
	entry_t       mem_wd;
	logic         emit, can_emit;
	logic [15:0]  emit_handle;
	dotq_status_t emit_status;
	logic         emit_last;
	logic         accept;
	logic         rd_due;
	logic         rd_later;
	cnt_t         cnt_dec, j_dec;

	function automatic addr_t phys(addr_t head, cnt_t l);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, l[AW-1:0]};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign accept   = in_valid && in_ready;
	assign can_emit = !out_valid_q || out_ready;
	assign rd_due   = rd_q[47:16] <= tval_q;
	assign rd_later = rd_q[47:16] > tval_q;
	assign cnt_dec  = cnt_q - cnt_t'(1);
	assign j_dec    = j_q - cnt_t'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_SCHEDULE) begin
						if (cnt_q == cnt_t'(DEPTH)) begin
							state_d = ST_ACK;
						end else if (cnt_q == '0) begin
							state_d = ST_INS_PUT;
						end else begin
							state_d = ST_INS_CMP;
						end
					end else begin
						state_d = (cnt_q == '0) ? ST_ACK : ST_EXP_CMP;
					end
				end
			end
			ST_INS_CMP: begin
				if (rd_later) begin
					if (j_dec == '0) begin
						state_d = ST_INS_PUT;
					end
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_INS_PUT: state_d = ST_ACK;
			ST_EXP_CMP: begin
				if (rd_due) begin
					if (!pend_valid_q || can_emit) begin
						if (cnt_dec == '0) begin
							state_d = ST_EXP_FIN;
						end
					end
				end else begin
					state_d = pend_valid_q ? ST_EXP_FIN : ST_ACK;
				end
			end
			ST_EXP_FIN: if (can_emit) state_d = ST_IDLE;
			ST_ACK:     if (can_emit) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = state_q == ST_IDLE;
		mem_we      = 1'b0;
		mem_wa      = phys(head_q, j_q);
		mem_wd      = {tval_q, hnd_q};
		mem_re      = 1'b0;
		mem_ra      = head_q;
		emit        = 1'b0;
		emit_handle = '0;
		emit_status = ack_status_q;
		emit_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cnt_q != '0 && cnt_q != cnt_t'(DEPTH)
					&& func == FUNC_SCHEDULE) begin
					mem_re = 1'b1;
					mem_ra = phys(head_q, cnt_dec);
				end else if (accept && cnt_q != '0 && func == FUNC_EXPIRE) begin
					mem_re = 1'b1;
					mem_ra = head_q;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (rd_later) begin
					mem_wd = rd_q;
					if (j_dec != '0) begin
						mem_re = 1'b1;
						mem_ra = phys(head_q, j_dec - cnt_t'(1));
					end
				end
			end
			ST_INS_PUT: mem_we = 1'b1;
			ST_EXP_CMP: begin
				if (rd_due && (!pend_valid_q || can_emit)) begin
					emit        = pend_valid_q;
					emit_handle = pend_q;
					emit_status = STATUS_FIRED;
					emit_last   = 1'b0;
					if (cnt_dec != '0) begin
						mem_re = 1'b1;
						mem_ra = phys(head_q, cnt_t'(1));
					end
				end
			end
			ST_EXP_FIN: begin
				emit        = 1'b1;
				emit_handle = pend_q;
				emit_status = STATUS_FIRED;
			end
			ST_ACK:  emit = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: pend_valid_q <= 1'b0;
				ST_INS_CMP: if (!rd_later) cnt_q <= cnt_q + cnt_t'(1);
				ST_INS_PUT: cnt_q <= cnt_q + cnt_t'(1);
				ST_EXP_CMP: begin
					if (rd_due && (!pend_valid_q || can_emit)) begin
						pend_valid_q <= 1'b1;
						head_q       <= phys(head_q, cnt_t'(1));
						cnt_q        <= cnt_dec;
					end
				end
				default: pend_valid_q <= pend_valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tval_q <= time_value;
			hnd_q  <= task_handle;
			j_q    <= cnt_q;
			if (func == FUNC_SCHEDULE) begin
				ack_status_q <= (cnt_q == cnt_t'(DEPTH)) ? STATUS_FULL : STATUS_ACCEPTED;
			end else begin
				ack_status_q <= STATUS_NOTHING;
			end
		end
		if (state_q == ST_INS_CMP && rd_later) begin
			j_q <= j_dec;
		end
		if (state_q == ST_EXP_CMP && rd_due && (!pend_valid_q || can_emit)) begin
			pend_q <= rd_q[15:0];
		end
		if (emit && can_emit) begin
			out_handle_q <= emit_handle;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
			out_count_q  <= cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign fired_handle = out_handle_q;
	assign status       = out_status_q;
	assign last         = out_last_q;
	assign task_count   = 5'(out_count_q);

endmodule

// ===== tb/deadline_ordered_task_queue_test.sv =====
// Self-checking testbench for the deadline-ordered task queue: directed table, then random items.
module deadline_ordered_task_queue_test import dotq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic        func;
		logic [31:0] time_value;
		logic [15:0] task_handle;
		logic        has_result;
		logic [15:0] fired_handle;
		dotq_status_t status;
		logic        last;
		logic [4:0]  task_count;
	} stim_row_t;

	typedef struct packed {
		logic [15:0]  fired_handle;
		dotq_status_t status;
		logic         last;
		logic [4:0]   task_count;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = FUNC_SCHEDULE;
	logic [31:0] time_value = '0;
	logic [15:0] task_handle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] fired_handle;
	logic [1:0]  status;
	logic        last;
	logic [4:0]  task_count;

	logic [31:0] queue_due[$];
	logic [15:0] queue_handle[$];
	result_t pending_results[$];
	stim_row_t directed_rows[$];
	int errors = 0;
	int idle_cycles = 0;
	bit sending_done = 1'b0;
	bit quiet_phase = 1'b0;
	bit hold_off = 1'b0;

	deadline_ordered_task_queue #(.DEPTH(DEPTH)) u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t make_result(logic [15:0] h, dotq_status_t s, logic l, int c);
		result_t r;
		r.fired_handle = h;
		r.status = s;
		r.last = l;
		r.task_count = 5'(c);
		return r;
	endfunction

	// Applies one accepted item to the model queue and records the results it causes.
	task automatic predict_queue(input logic f, input logic [31:0] t, input logic [15:0] h);
		int pos;
		int n;
		int k;
		pos = 0;
		n = queue_due.size();
		if (f == FUNC_SCHEDULE) begin
			if (n >= DEPTH) begin
				pending_results.push_back(make_result('0, STATUS_FULL, 1'b1, n));
			end else begin
				while (pos < n && queue_due[pos] <= t) pos++;
				queue_due.insert(pos, t);
				queue_handle.insert(pos, h);
				pending_results.push_back(make_result('0, STATUS_ACCEPTED, 1'b1, n + 1));
			end
		end else begin
			k = 0;
			while (k < n && queue_due[k] <= t) k++;
			if (k == 0) pending_results.push_back(make_result('0, STATUS_NOTHING, 1'b1, n));
			for (int i = 0; i < k; i++) begin
				pending_results.push_back(make_result(queue_handle[0], STATUS_FIRED,
					i == k - 1, n - i - 1));
				queue_due.pop_front();
				queue_handle.pop_front();
			end
		end
	endtask

	task automatic send_item(input logic f, input logic [31:0] t, input logic [15:0] h);
		if (!quiet_phase && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!quiet_phase && $urandom_range(99) < 6);
		end
		in_valid <= 1'b1;
		func <= f;
		time_value <= t;
		task_handle <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_queue(f, t, h);
	endtask

	function automatic stim_row_t row(logic f, logic [31:0] t, logic [15:0] h, logic has = 0,
			logic [15:0] fh = 0, dotq_status_t s = STATUS_ACCEPTED, logic l = 1, int c = 0);
		stim_row_t r;
		r.func = f;
		r.time_value = t;
		r.task_handle = h;
		r.has_result = has;
		r.fired_handle = fh;
		r.status = s;
		r.last = l;
		r.task_count = 5'(c);
		return r;
	endfunction

	initial begin
		logic [31:0] t;
		directed_rows.push_back(row(FUNC_EXPIRE, 32'hFFFF_FFFF, 16'h0000, 1, 0,
			STATUS_NOTHING, 1, 0));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 1, 0,
			STATUS_ACCEPTED, 1, 1));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h0000_0000, 16'h0000, 1, 0,
			STATUS_ACCEPTED, 1, 2));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h0000_0005, 16'h1234));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h0000_0005, 16'h5678));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h0000_0005, 16'hAAAA));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h8000_0000, 16'h5555));
		directed_rows.push_back(row(FUNC_EXPIRE, 32'h0000_0000, 16'hFFFF, 1, 0,
			STATUS_FIRED, 1, 5));
		directed_rows.push_back(row(FUNC_EXPIRE, 32'h0000_0004, 16'h0000, 1, 0,
			STATUS_NOTHING, 1, 5));
		directed_rows.push_back(row(FUNC_EXPIRE, 32'h0000_0005, 16'h0000));
		for (int i = 0; i < 14; i++)
			directed_rows.push_back(row(FUNC_SCHEDULE, 32'h7FFF_FFFF - i, 16'(i * 4099)));
		directed_rows.push_back(row(FUNC_SCHEDULE, 32'h0000_0001, 16'hBEEF, 1, 0,
			STATUS_FULL, 1, 16));
		directed_rows.push_back(row(FUNC_EXPIRE, 32'hFFFF_FFFF, 16'h0000));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].func, directed_rows[i].time_value,
				directed_rows[i].task_handle);
			if (directed_rows[i].has_result) begin
				pending_results[pending_results.size() - 1] = make_result(
					directed_rows[i].fired_handle, directed_rows[i].status,
					directed_rows[i].last, directed_rows[i].task_count);
			end
		end
		for (int i = 0; i < 134; i++) begin
			quiet_phase = (i >= 60 && i < 90);
			if (i == 100) hold_off = 1'b1;
			t = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(200));
			if ($urandom_range(99) < 65)
				send_item(FUNC_SCHEDULE, t, 16'($urandom));
			else
				send_item(FUNC_EXPIRE, t, 16'($urandom));
		end
		send_item(FUNC_EXPIRE, 32'hFFFF_FFFF, 16'h0000);
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// The receiver stalls at random, and once holds off long enough for the input to back up.
	initial begin
		int gap;
		while (1) begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				gap = 0;
				while (gap < 200) begin
					@(posedge clk);
					gap++;
				end
				hold_off = 1'b0;
			end
			out_ready <= quiet_phase || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result handle %h status %0d last %0d count %0d",
					$time, fired_handle, status, last, task_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (fired_handle !== want.fired_handle)
					$display("%0t: fired_handle expected %h actual %h",
						$time, want.fired_handle, fired_handle);
				if (status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				if (last !== want.last)
					$display("%0t: last expected %0d actual %0d", $time, want.last, last);
				if (task_count !== want.task_count)
					$display("%0t: task_count expected %0d actual %0d",
						$time, want.task_count, task_count);
				if (fired_handle !== want.fired_handle || status !== want.status
						|| last !== want.last || task_count !== want.task_count)
					errors++;
			end
		end
	end

	initial begin
		while (!(sending_done && pending_results.size() == 0)) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("deadline_ordered_task_queue_test: FAIL");
				$finish;
			end
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("deadline_ordered_task_queue_test: PASS");
		else
			$display("deadline_ordered_task_queue_test: FAIL");
		$finish;
	end

endmodule
